FILE: hdl/radix2_fft_core_assert.svh
// ----------------------------------------------------------------------------
// radix2_fft_core_assert.svh
// Assertion macros used by the FFT core checker.
// ----------------------------------------------------------------------------
`ifndef RADIX2_FFT_CORE_ASSERT_SVH
`define RADIX2_FFT_CORE_ASSERT_SVH

// Clocked implication with reset disable.
`define RFFT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rfft assertion failed");

// Signal holds in the cycle after a condition.
`define RFFT_ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error("rfft signal changed while held");

`endif

FILE: hdl/rfft_pkg.sv
// ----------------------------------------------------------------------------
// rfft_pkg
// Shared widths, types and the twiddle table of the FFT core.
// ----------------------------------------------------------------------------
`default_nettype none

package rfft_pkg;

  localparam int POINTS       = 64;
  localparam int LOG2         = $clog2(POINTS);
  localparam int SAMPLE_BITS  = 16;
  localparam int TWIDDLE_BITS = 16;
  localparam int IN_W         = 16;
  localparam int BIN_BITS     = 22;
  localparam int IDX_W        = 6;
  // one bit of headroom past the worst-case component growth
  localparam int WORK_BITS    = SAMPLE_BITS + LOG2 + 2;
  localparam int TW_W         = TWIDDLE_BITS + 1;
  localparam int ROM_LOG2     = 6;
  localparam int STG_W        = $clog2(LOG2 + 1);

  typedef struct packed {
    logic [LOG2-1:0]                addr;
    logic signed [SAMPLE_BITS-1:0]  re;
    logic signed [SAMPLE_BITS-1:0]  im;
    logic                           last;
  } load_t;

  typedef struct packed {
    logic signed [TW_W-1:0] re;
    logic signed [TW_W-1:0] im;
  } tw_t;

  // sin(pi*n/32) in Q1.23, n = 0..16
  localparam int QSINE [17] = '{
    0, 822227, 1636536, 2435084, 3210181, 3954362, 4660461, 5321677,
    5931642, 6484482, 6974873, 7398092, 7750063, 8027397, 8227423,
    8348215, 8388608
  };

  localparam int TW_SH = 24 - TWIDDLE_BITS;

  function automatic int tw_round(int v);
    int r;
    if (TW_SH > 0) r = (v + (1 << (TW_SH - 1))) >>> TW_SH;
    else r = v;
    return r;
  endfunction

  // exp(-2*pi*i*t/64) for t = 0..31, the lower half plane of the circle
  function automatic tw_t twiddle(logic [ROM_LOG2-2:0] t);
    tw_t w;
    int  ti;
    int  cmag;
    int  smag;
    ti = int'(t);
    if (ti <= 16) begin
      cmag = tw_round(QSINE[16 - ti]);
      smag = tw_round(QSINE[ti]);
      w.re = TW_W'(cmag);
    end else begin
      cmag = tw_round(QSINE[ti - 16]);
      smag = tw_round(QSINE[32 - ti]);
      w.re = TW_W'(-cmag);
    end
    w.im = TW_W'(-smag);
    return w;
  endfunction

  // clamp a work value to the bin range
  function automatic logic [BIN_BITS-1:0] bin_sat(logic signed [WORK_BITS-1:0] v);
    logic signed [WORK_BITS-1:0] hi;
    logic signed [WORK_BITS-1:0] lo;
    logic [BIN_BITS-1:0]         r;
    hi = WORK_BITS'((64'sd1 <<< (BIN_BITS - 1)) - 64'sd1);
    lo = WORK_BITS'(-(64'sd1 <<< (BIN_BITS - 1)));
    if (v > hi) r = hi[BIN_BITS-1:0];
    else if (v < lo) r = lo[BIN_BITS-1:0];
    else r = v[BIN_BITS-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rfft_if.sv
// ----------------------------------------------------------------------------
// rfft_if
// Sample and bin channels of the FFT core.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfft_sample_if
  import rfft_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] sample_re;
  logic signed [IN_W-1:0] sample_im;

  modport source (output valid, sample_re, sample_im, input ready);
  modport sink   (input valid, sample_re, sample_im, output ready);
endinterface

interface rfft_bin_if
  import rfft_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [BIN_BITS-1:0] bin_re;
  logic signed [BIN_BITS-1:0] bin_im;
  logic [IDX_W-1:0]           bin_index;
  logic                       last_bin;

  modport source (output valid, bin_re, bin_im, bin_index, last_bin, input ready);
  modport sink   (input valid, bin_re, bin_im, bin_index, last_bin, output ready);
endinterface

`default_nettype wire

FILE: hdl/rfft_queue.sv
// ----------------------------------------------------------------------------
// rfft_queue
// Two-entry queue between sample loader and transform engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rfft_queue
  import rfft_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  load_t push_data_i,
  output logic  full_o,
  input  wire   pop_i,
  output logic  empty_o,
  output load_t pop_data_o
);

  load_t      slot_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q[1];
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = slot_q[rp_q];

  // advance pointers and fill count
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d  = ~wp_q;
      cnt_d = cnt_d + 2'd1;
    end
    if (pop_i) begin
      rp_d  = ~rp_q;
      cnt_d = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // store pushed entry
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= push_data_i;
  end

endmodule

`default_nettype wire

FILE: hdl/rfft_front.sv
// ----------------------------------------------------------------------------
// rfft_front
// Accepts samples, counts the frame and tags each beat with its
// bit-reversed store address and an end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rfft_front
  import rfft_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  rfft_sample_if.sink in_s,
  input  wire        q_full_i,
  output logic       q_push_o,
  output load_t      q_data_o
);

  logic [LOG2-1:0] count_q, count_d;
  logic [LOG2-1:0] rev;

  assign in_s.ready = ~q_full_i;
  assign q_push_o   = in_s.valid & ~q_full_i;

  // reverse sample counter bits
  always_comb begin
    for (int n = 0; n < LOG2; n++) rev[n] = count_q[LOG2-1-n];
  end

  assign q_data_o.addr = rev;
  assign q_data_o.re   = in_s.sample_re[SAMPLE_BITS-1:0];
  assign q_data_o.im   = in_s.sample_im[SAMPLE_BITS-1:0];
  assign q_data_o.last = (count_q == LOG2'(POINTS - 1));

  // advance and wrap the load count
  always_comb begin
    count_d = count_q;
    if (q_push_o) begin
      if (q_data_o.last) count_d = '0;
      else count_d = count_q + LOG2'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rfft_engine.sv
// ----------------------------------------------------------------------------
// rfft_engine
// Writes queued samples into the work store, runs the butterfly stages
// on one shared butterfly and unloads the bins in natural order.
// ----------------------------------------------------------------------------
`default_nettype none

module rfft_engine
  import rfft_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         q_empty_i,
  input  load_t       q_data_i,
  output logic        q_pop_o,
  rfft_bin_if.source  out_m
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;
  localparam logic [3:0] S_RB   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_WA   = 4'd5;
  localparam logic [3:0] S_WB   = 4'd6;
  localparam logic [3:0] S_ORD  = 4'd7;
  localparam logic [3:0] S_OLD  = 4'd8;
  localparam logic [3:0] S_OWT  = 4'd9;

  localparam int PROD_W = WORK_BITS + TW_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int FRAC   = TWIDDLE_BITS - 1;
  localparam int PW     = WORK_BITS + 1;

  logic [3:0]       state_q, state_d;
  logic [STG_W-1:0] stage_q, stage_d;
  logic [LOG2-1:0]  bfly_q, bfly_d;
  logic [LOG2-1:0]  idx_q, idx_d;

  logic [2*WORK_BITS-1:0] mem [POINTS];
  logic [2*WORK_BITS-1:0] rd_data_q;
  logic [LOG2-1:0]        rd_addr;
  logic                   we;
  logic [LOG2-1:0]        wa;
  logic [2*WORK_BITS-1:0] wd;

  logic signed [WORK_BITS-1:0] top_re_q, top_im_q;
  logic signed [WORK_BITS-1:0] rd_re, rd_im;
  tw_t                         tw_q;
  logic signed [PROD_W-1:0]    p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [PW-1:0]        pr_q, pi_q;
  logic signed [SUM_W-1:0]     sum_re, sum_im;
  logic signed [WORK_BITS-1:0] a_re, a_im, b_re, b_im;

  logic [LOG2-1:0]     mask, lowb, addr_a, addr_b;
  logic [LOG2:0]       a_full;
  logic [ROM_LOG2-1:0] tidx;

  logic signed [BIN_BITS-1:0] bin_re_q, bin_im_q;
  logic                       valid_q;

  // butterfly addressing: insert a zero bit at the stage position
  always_comb begin
    mask   = LOG2'((1 << stage_q) - 1);
    lowb   = bfly_q & mask;
    a_full = (((LOG2 + 1)'(bfly_q) >> stage_q) << (stage_q + STG_W'(1)))
             | (LOG2 + 1)'(lowb);
    addr_a = a_full[LOG2-1:0];
    addr_b = addr_a | LOG2'(1 << stage_q);
    tidx   = ROM_LOG2'(ROM_LOG2'(lowb) << (STG_W'(ROM_LOG2 - 1) - stage_q));
  end

  assign rd_re = $signed(rd_data_q[2*WORK_BITS-1:WORK_BITS]);
  assign rd_im = $signed(rd_data_q[WORK_BITS-1:0]);

  // butterfly outputs
  assign a_re = WORK_BITS'(top_re_q + pr_q);
  assign a_im = WORK_BITS'(top_im_q + pi_q);
  assign b_re = WORK_BITS'(top_re_q - pr_q);
  assign b_im = WORK_BITS'(top_im_q - pi_q);

  // twiddled operand sums before rounding
  assign sum_re = SUM_W'(p_rr_q) - SUM_W'(p_ii_q) + (SUM_W'(1) <<< (FRAC - 1));
  assign sum_im = SUM_W'(p_ri_q) + SUM_W'(p_ir_q) + (SUM_W'(1) <<< (FRAC - 1));

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = addr_a;
    wd = {a_re, a_im};
    unique case (state_q)
      S_LOAD: begin
        we = ~q_empty_i;
        wa = q_data_i.addr;
        wd = {WORK_BITS'(q_data_i.re), WORK_BITS'(q_data_i.im)};
      end
      S_WA: we = 1'b1;
      S_WB: begin
        we = 1'b1;
        wa = addr_b;
        wd = {b_re, b_im};
      end
      default: we = 1'b0;
    endcase
    unique case (state_q)
      S_RB:    rd_addr = addr_b;
      S_ORD:   rd_addr = idx_q;
      default: rd_addr = addr_a;
    endcase
  end

  assign q_pop_o = (state_q == S_LOAD) & ~q_empty_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    bfly_d  = bfly_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_LOAD: begin
        if (!q_empty_i && q_data_i.last) begin
          state_d = S_RA;
          stage_d = '0;
          bfly_d  = '0;
        end
      end
      S_RA:  state_d = S_RB;
      S_RB:  state_d = S_MUL;
      S_MUL: state_d = S_ADD;
      S_ADD: state_d = S_WA;
      S_WA:  state_d = S_WB;
      S_WB: begin
        if (bfly_q == LOG2'(POINTS / 2 - 1)) begin
          bfly_d = '0;
          if (stage_q == STG_W'(LOG2 - 1)) begin
            state_d = S_ORD;
            idx_d   = '0;
          end else begin
            stage_d = stage_q + STG_W'(1);
            state_d = S_RA;
          end
        end else begin
          bfly_d  = bfly_q + LOG2'(1);
          state_d = S_RA;
        end
      end
      S_ORD: state_d = S_OLD;
      S_OLD: state_d = S_OWT;
      S_OWT: begin
        if (out_m.ready) begin
          if (idx_q == LOG2'(POINTS - 1)) begin
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + LOG2'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      stage_q <= '0;
      bfly_q  <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      bfly_q  <= bfly_d;
      idx_q   <= idx_d;
      if (state_q == S_OLD) valid_q <= 1'b1;
      else if (state_q == S_OWT && out_m.ready) valid_q <= 1'b0;
    end
  end

  // work store
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_data_q <= mem[rd_addr];
  end

  // butterfly datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_RB) begin
      top_re_q <= rd_re;
      top_im_q <= rd_im;
      tw_q     <= twiddle(tidx[ROM_LOG2-2:0]);
    end
    if (state_q == S_MUL) begin
      p_rr_q <= rd_re * tw_q.re;
      p_ii_q <= rd_im * tw_q.im;
      p_ri_q <= rd_re * tw_q.im;
      p_ir_q <= rd_im * tw_q.re;
    end
    if (state_q == S_ADD) begin
      pr_q <= PW'(sum_re >>> FRAC);
      pi_q <= PW'(sum_im >>> FRAC);
    end
    if (state_q == S_OLD) begin
      bin_re_q <= bin_sat(rd_re);
      bin_im_q <= bin_sat(rd_im);
    end
  end

  assign out_m.valid     = valid_q;
  assign out_m.bin_re    = bin_re_q;
  assign out_m.bin_im    = bin_im_q;
  assign out_m.bin_index = IDX_W'(idx_q);
  assign out_m.last_bin  = (idx_q == LOG2'(POINTS - 1));

endmodule

`default_nettype wire

FILE: hdl/radix2_fft_core.sv
// ----------------------------------------------------------------------------
// radix2_fft_core
// Forward 64-point radix-2 decimation-in-time FFT, unscaled, Q1.15 input.
//
// in_s carries complex samples (valid/ready). After the 64th sample of a
// frame, the core runs six butterfly stages and sends 64 bins on out_m in
// natural order, each with its index and last_bin on the final one.
// One shared butterfly works from a single-port-read, single-port-write
// store and steps each of its 192 butterflies through the read, multiply,
// add and write states S_RA, S_RB, S_MUL, S_ADD, S_WA and S_WB. Each bin
// is unloaded through S_ORD, S_OLD and S_OWT, in that order.
// Samples of the next frame are taken into a two-entry queue while the
// engine computes; the queue then holds ready low until loading resumes.
// A stalled receiver holds the current bin and pauses the unload.
// Reset clears the load count, the queue and the sequencer; the work store
// is not cleared, since each frame writes every entry before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module radix2_fft_core
  import rfft_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  rfft_sample_if.sink  in_s,
  rfft_bin_if.source   out_m
);

  load_t push_data;
  load_t pop_data;
  logic  push, pop, full, empty;

  rfft_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_s     (in_s),
    .q_full_i (full),
    .q_push_o (push),
    .q_data_o (push_data)
  );

  rfft_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  rfft_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (empty),
    .q_data_i  (pop_data),
    .q_pop_o   (pop),
    .out_m     (out_m)
  );

endmodule

`default_nettype wire

FILE: hdl/rfft_checker.sv
// ----------------------------------------------------------------------------
// rfft_checker
// Port-level checks of the FFT core output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix2_fft_core_assert.svh"

module rfft_checker
  import rfft_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                out_valid_i,
  input wire                out_ready_i,
  input wire [BIN_BITS-1:0] bin_re_i,
  input wire [IDX_W-1:0]    bin_index_i,
  input wire                last_bin_i
);

  logic [IDX_W-1:0] exp_idx_q;
  logic             stall;

  assign stall = out_valid_i & ~out_ready_i;

  // track the index the next bin must carry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      exp_idx_q <= last_bin_i ? '0 : exp_idx_q + IDX_W'(1);
    end
  end

  `RFFT_ASSERT(a_stall_keeps_valid, clk_i, rst_ni, stall |=> out_valid_i)
  `RFFT_ASSERT_HOLD(a_stall_keeps_bin, clk_i, rst_ni, stall, bin_re_i)
  `RFFT_ASSERT(a_index_order, clk_i, rst_ni, out_valid_i |-> bin_index_i == exp_idx_q)
  `RFFT_ASSERT(a_last_on_top, clk_i, rst_ni, out_valid_i |-> last_bin_i == (bin_index_i == IDX_W'(POINTS - 1)))

endmodule

bind radix2_fft_core rfft_checker u_rfft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_m.valid),
  .out_ready_i (out_m.ready),
  .bin_re_i    (out_m.bin_re),
  .bin_index_i (out_m.bin_index),
  .last_bin_i  (out_m.last_bin)
);

`default_nettype wire

FILE: tb/radix2_fft_core_tb.sv
// ----------------------------------------------------------------------------
// radix2_fft_core_tb
// Self-checking bench for the 64-point radix-2 FFT core. Frames of complex
// samples are sent, and an in-bench fixed-point FFT computes the expected
// bins. Each output beat is checked field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module radix2_fft_core_tb;
  import rfft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME     = 64;
  localparam int STAGES    = 6;
  localparam int STALL_MAX = 20000;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } sample_t;

  typedef struct {
    logic signed [21:0] re;
    logic signed [21:0] im;
    logic [5:0]         idx;
    logic               last;
  } bin_t;

  // sin(pi*n/32) in Q1.23
  localparam int SINE_Q23 [17] = '{
    0, 822227, 1636536, 2435084, 3210181, 3954362, 4660461, 5321677,
    5931642, 6484482, 6974873, 7398092, 7750063, 8027397, 8227423,
    8348215, 8388608
  };

  logic clk_i;
  logic rst_ni;

  rfft_sample_if in_s ();
  rfft_bin_if    out_m ();

  radix2_fft_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_s  (in_s.sink),
    .out_m (out_m.source)
  );

  // Clock: 4 ns period
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sample_t     pending_samples[$];
  bin_t        expected_bins[$];
  longint      frame_re[FRAME];
  longint      frame_im[FRAME];
  int          frame_fill;
  int          mismatch_count;
  int          bins_seen;
  int          samples_sent;
  int          quiet_cycles;
  bit          drain_pause;
  bit          calm_tail;
  int          send_gap;
  int          recv_gap;

  // Round half up, then floor by f bits
  function automatic longint round_floor(longint p, int f);
    return (p + (64'sd1 <<< (f - 1))) >>> f;
  endfunction

  function automatic logic [5:0] bit_rev6(int v);
    logic [5:0] r;
    for (int i = 0; i < 6; i++) r[i] = v[5 - i];
    return r;
  endfunction

  function automatic logic signed [21:0] clamp_bin(longint v);
    if (v > 2097151) return 22'sd2097151;
    if (v < -2097152) return -22'sd2097152;
    return v[21:0];
  endfunction

  // Butterfly stages over the loaded frame, then queue all 64 bins
  task automatic compute_spectrum();
    longint wr, wi, pr, pi, tr, ti, cm, sm;
    int     t, a, b;
    for (int half = 1; half < FRAME; half <<= 1) begin
      for (int base = 0; base < FRAME; base += 2 * half) begin
        for (int n = 0; n < half; n++) begin
          a = base + n;
          b = a + half;
          t = (n * (FRAME / (2 * half))) & 31;
          if (t <= 16) begin
            cm = (SINE_Q23[16 - t] + 128) >>> 8;
            sm = (SINE_Q23[t] + 128) >>> 8;
            wr = cm;
          end else begin
            cm = (SINE_Q23[t - 16] + 128) >>> 8;
            sm = (SINE_Q23[32 - t] + 128) >>> 8;
            wr = -cm;
          end
          wi = -sm;
          pr = round_floor(frame_re[b] * wr - frame_im[b] * wi, 15);
          pi = round_floor(frame_re[b] * wi + frame_im[b] * wr, 15);
          tr = frame_re[a];
          ti = frame_im[a];
          frame_re[a] = tr + pr;
          frame_im[a] = ti + pi;
          frame_re[b] = tr - pr;
          frame_im[b] = ti - pi;
        end
      end
    end
    for (int k = 0; k < FRAME; k++) begin
      expected_bins.push_back('{clamp_bin(frame_re[k]), clamp_bin(frame_im[k]),
                                k[5:0], k == FRAME - 1});
    end
  endtask

  // Model one accepted sample beat
  task automatic load_sample(sample_t s);
    logic [5:0] addr;
    addr = bit_rev6(frame_fill);
    frame_re[addr] = s.re;
    frame_im[addr] = s.im;
    frame_fill++;
    if (frame_fill == FRAME) begin
      compute_spectrum();
      frame_fill = 0;
    end
  endtask

  function automatic sample_t rand_sample(int mode);
    sample_t s;
    case (mode)
      0: begin
        s.re = 16'($urandom);
        s.im = 16'($urandom);
      end
      1: begin
        s.re = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        s.im = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      default: begin
        s.re = $signed(16'($urandom_range(0, 511))) - 16'sd256;
        s.im = $signed(16'($urandom_range(0, 511))) - 16'sd256;
      end
    endcase
    return s;
  endfunction

  // Directed frames, then random frames of mixed character
  initial begin
    sample_t s;
    int      mode;
    // impulse at full scale: positive real, negative imaginary
    for (int i = 0; i < FRAME; i++) begin
      s.re = (i == 0) ? 16'sh7fff : 16'sh0000;
      s.im = (i == 0) ? 16'sh8000 : 16'sh0000;
      pending_samples.push_back(s);
    end
    // aligned extremes: constant max real and min imaginary, then alternating min/max
    for (int i = 0; i < FRAME; i++) begin
      s.re = 16'sh7fff;
      s.im = 16'sh8000;
      pending_samples.push_back(s);
    end
    for (int i = 0; i < FRAME; i++) begin
      s.re = i[0] ? 16'sh8000 : 16'sh7fff;
      s.im = i[0] ? 16'sh7fff : 16'sh8000;
      pending_samples.push_back(s);
    end
    for (int f = 0; f < 2; f++) begin
      mode = f % 3;
      for (int i = 0; i < FRAME; i++) pending_samples.push_back(rand_sample(mode));
    end
    // partial frame: sent after the pause, completed afterwards
    for (int i = 0; i < 16; i++) pending_samples.push_back(rand_sample(0));
  end

  // Sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_s.valid     <= 1'b0;
      in_s.sample_re <= '0;
      in_s.sample_im <= '0;
      send_gap       <= 0;
      samples_sent   <= 0;
      drain_pause    <= 1'b0;
    end else begin
      automatic bit fire = in_s.valid && in_s.ready;
      automatic bit busy = in_s.valid && !fire;
      if (fire) begin
        load_sample('{in_s.sample_re, in_s.sample_im});
        samples_sent <= samples_sent + 1;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_s.valid <= 1'b0;
        end else if (samples_sent + fire == 5 * FRAME && !drain_pause) begin
          // hold off until every bin so far has come out
          in_s.valid <= 1'b0;
          if (expected_bins.size() == 0 && fire == 0) drain_pause <= 1'b1;
        end else if (pending_samples.size() != 0) begin
          automatic sample_t s = pending_samples.pop_front();
          in_s.valid     <= 1'b1;
          in_s.sample_re <= s.re;
          in_s.sample_im <= s.im;
          if (!calm_tail && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 18);
        end else begin
          in_s.valid <= 1'b0;
        end
      end
    end
  end

  // Bin receiver with random stalls, and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_m.ready    <= 1'b0;
      recv_gap       <= 0;
      mismatch_count <= 0;
      bins_seen      <= 0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        bins_seen <= bins_seen + 1;
        if (expected_bins.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected bin beat idx=%0d", out_m.bin_index);
        end else begin
          automatic bin_t e = expected_bins.pop_front();
          if (e.re !== out_m.bin_re || e.im !== out_m.bin_im
              || e.idx !== out_m.bin_index || e.last !== out_m.last_bin) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("bin mismatch exp re=%0d im=%0d k=%0d l=%0b got re=%0d im=%0d k=%0d l=%0b",
                       e.re, e.im, e.idx, e.last, out_m.bin_re, out_m.bin_im,
                       out_m.bin_index, out_m.last_bin);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_m.ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
        recv_gap    <= $urandom_range(1, 18);
        out_m.ready <= 1'b0;
      end else begin
        out_m.ready <= 1'b1;
      end
    end
  end

  // Stall watchdog: cycles with no beat on either channel end the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_s.valid && in_s.ready) || (out_m.valid && out_m.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Reset, random frame tail, end of run
  initial begin
    rst_ni      = 1'b0;
    calm_tail   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (drain_pause);
    // finish the partial frame
    for (int i = 16; i < FRAME; i++) pending_samples.push_back(rand_sample(0));
    // last frame goes out with no random send gaps or receiver stalls
    wait (pending_samples.size() == 0);
    calm_tail = 1'b1;
    for (int i = 0; i < FRAME; i++) pending_samples.push_back(rand_sample($urandom_range(0, 2)));
    wait (pending_samples.size() == 0 && !in_s.valid && expected_bins.size() == 0
          && frame_fill == 0);
    repeat (200) @(posedge clk_i);
    $display("Ran %0d samples in %0d frames, %0d bins checked, %0d mismatches.",
             samples_sent, samples_sent / FRAME, bins_seen, mismatch_count);
    if (mismatch_count == 0 && expected_bins.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
